// File: hdl/surface_distance_gap_hold_core_macros.svh
// Assertion macros for the surface distance gap hold core.
// Include from a module body that has clk_i and rst_ni in scope.
`ifndef SURFACE_DISTANCE_GAP_HOLD_CORE_MACROS_SVH
`define SURFACE_DISTANCE_GAP_HOLD_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SDGH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SDGH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sdgh_pkg.sv
// Shared types and constants for the surface distance gap hold core.
// No dependencies; imported by sdgh_tilt and surface_distance_gap_hold_core.
`timescale 1ns / 1ps

package sdgh_pkg;

  typedef enum logic [1:0] {
    SurfNone    = 2'd0,
    SurfGround  = 2'd1,
    SurfCeiling = 2'd2
  } surf_e;

  typedef enum logic [1:0] {
    CfgSurface = 2'd0,
    CfgTimeout = 2'd1,
    CfgGapThr  = 2'd2,
    CfgGapHold = 2'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [1:0]  SurfaceRst = 2'd1;
  localparam logic [15:0] TimeoutRst = 16'd1500;
  localparam logic [15:0] GapThrRst  = 16'd500;
  localparam logic [15:0] GapHoldRst = 16'd2500;

  // Held distance at or below this reads as an empty memory
  localparam logic [15:0] MemEmptyMm = 16'd50;
  localparam logic [15:0] OutLimit   = 16'd65535;

  localparam int DistW = 16;
  localparam int OutW  = 17;

  // Input tdata layout, lowest bit first
  localparam int InNowLo   = 0;
  localparam int InOkBit   = 32;
  localparam int InGfBit   = 33;
  localparam int InDistLo  = 34;
  localparam int InStampLo = 50;
  localparam int InTiltLo  = 82;
  localparam int InAutoBit = 98;
  localparam int InDataW   = 104;
  localparam int OutDataW  = 40;

  typedef struct packed {
    logic                   target_set;
    logic signed [OutW-1:0] target_down_mm;
    logic                   init_cmd;
    logic signed [OutW-1:0] init_down_mm;
    logic                   logging_valid;
  } res_t;

endpackage

// File: hdl/sdgh_tilt.sv
// Tilt correction: distance times Q1.14 cosine, rounded, negated, saturated.
// Depends on sdgh_pkg.
`timescale 1ns / 1ps

module sdgh_tilt
  import sdgh_pkg::*;
(
  input  logic        [DistW-1:0] dist_i,
  input  logic signed [15:0]      tilt_cos_i,
  output logic signed [OutW-1:0]  down_o
);

  logic        neg;
  logic [16:0] tmag;
  logic [32:0] prod;
  logic [33:0] rnd;
  logic [19:0] q;
  logic [15:0] mag;

  always_comb begin
    neg  = tilt_cos_i[15];
    tmag = neg ? (17'h10000 - {1'b0, tilt_cos_i}) : {1'b0, tilt_cos_i};
    prod = 33'(dist_i) * 33'(tmag);
    // round half away from zero on the magnitude
    rnd  = 34'(prod) + 34'd8192;
    q    = rnd[33:14];
    mag  = (q > 20'(OutLimit)) ? OutLimit : q[15:0];
    // a negative cosine gives a positive down value
    down_o = neg ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
  end

endmodule

// File: hdl/surface_distance_gap_hold_core.sv
// Top level of the surface distance gap hold core.
// Depends on sdgh_pkg, sdgh_tilt and surface_distance_gap_hold_core_macros.svh.
`timescale 1ns / 1ps
//
// Qualifies rangefinder samples for ground or ceiling tracking.
// Slave stream: one beat per update; s_axis_tuser is the kind (0 sample, 1 re-arm).
// Master stream: exactly one result beat per input beat, in order.
// Config channel: cfg_addr_i selects the register (0 surface, 1 timeout,
// 2 gap threshold, 3 gap hold); always ready, write only while idle.
// An accepted beat reaches the master side via the input and result registers.
// Throughput: one beat per cycle while not stalled; the input and result
// registers each hold one beat, and the tracking state updates in the same
// cycle the beat enters the result register, so the next beat sees it at once.
// The per-beat path is one 16x17 multiply for the tilt correction.
// A stalled master side holds the result; the input register still takes one
// more beat, then s_axis_tready drops until the result moves.
// Reset clears the tracking state, sets the applied surface to ground, loads
// the register defaults and empties both registers.
`include "surface_distance_gap_hold_core_macros.svh"

module surface_distance_gap_hold_core
  import sdgh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: now_ms[31:0], sensor_ok, glitch_free, distance_mm[15:0],
  //        glitch_cleared_stamp[31:0], tilt_cos[15:0], auto_mode, zero pad
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: target_set, target_down_mm[16:0], init_cmd, init_down_mm[16:0],
  //        logging_valid, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i
);

  // configuration
  logic [1:0]  surf_sel_q;
  logic [15:0] timeout_q, gap_thr_q, gap_hold_q;

  // beat registers
  logic               in_vld_q, out_vld_q;
  logic [InDataW-1:0] in_data_q;
  logic               in_mode_q;
  res_t               out_q, res_d;
  logic               advance;

  // tracking state
  logic [31:0] lut_q, lut_d;
  logic        rp_q, rp_d;
  logic [31:0] stamp_q, stamp_d;
  logic [15:0] held_q, held_d;
  logic [31:0] gap_start_q, gap_start_d;
  logic        gap_act_q, gap_act_d;
  logic        valid_q, valid_d;
  surf_e       applied_q, applied_d;

  // fields of the beat in the input register
  logic [31:0]        now;
  logic               ok, autom;
  logic [15:0]        dist_mm;
  logic [31:0]        stamp;
  logic signed [15:0] tilt;

  logic [15:0]        filt;
  logic signed [OutW-1:0] tdown;

  assign now     = in_data_q[InNowLo +: 32];
  assign ok      = in_data_q[InOkBit] & in_data_q[InGfBit];
  assign dist_mm = in_data_q[InDistLo +: 16];
  assign stamp   = in_data_q[InStampLo +: 32];
  assign tilt    = $signed(in_data_q[InTiltLo +: 16]);
  assign autom   = in_data_q[InAutoBit];

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.logging_valid, out_q.init_down_mm, out_q.init_cmd,
                          out_q.target_down_mm, out_q.target_set};

  sdgh_tilt u_tilt (
    .dist_i     (filt),
    .tilt_cos_i (tilt),
    .down_o     (tdown)
  );

  always_comb begin
    surf_e       sel;
    logic        timeout, tracking, gap;
    logic [15:0] h1;
    logic [31:0] start_eff;

    case (surf_e'(surf_sel_q))
      SurfGround:  sel = SurfGround;
      SurfCeiling: sel = SurfCeiling;
      default:     sel = SurfNone;
    endcase

    lut_d       = lut_q;
    rp_d        = rp_q;
    stamp_d     = stamp_q;
    held_d      = held_q;
    gap_start_d = gap_start_q;
    gap_act_d   = gap_act_q;
    valid_d     = valid_q;
    applied_d   = sel;
    filt        = dist_mm;
    h1          = held_q;
    gap         = 1'b0;
    start_eff   = now;
    res_d       = '0;

    // surface change: restart tracking from an empty memory
    if (sel != applied_q) begin
      rp_d        = 1'b1;
      held_d      = '0;
      gap_start_d = '0;
      gap_act_d   = 1'b0;
    end

    timeout  = (now - lut_q) > {16'b0, timeout_q};
    tracking = ok && (sel == SurfGround || sel == SurfCeiling);

    if (in_mode_q) begin
      if (sel == SurfGround && ok) begin
        lut_d = now;
        rp_d  = 1'b0;
      end
    end else if (tracking) begin
      if (sel == SurfGround) begin
        if (!autom) begin
          held_d      = dist_mm;
          gap_act_d   = 1'b0;
          gap_start_d = '0;
        end else begin
          h1  = (held_d <= MemEmptyMm) ? dist_mm : held_d;
          gap = {1'b0, dist_mm} > ({1'b0, h1} + {1'b0, gap_thr_q});
          if (gap) begin
            start_eff = gap_act_d ? gap_start_d : now;
            if (!gap_act_d) begin
              gap_act_d   = 1'b1;
              gap_start_d = now;
            end
            // hold the last good distance until the gap outlasts the hold time
            if ((now - start_eff) < {16'b0, gap_hold_q}) begin
              filt   = h1;
              held_d = h1;
            end else begin
              held_d = dist_mm;
            end
          end else begin
            gap_act_d   = 1'b0;
            gap_start_d = '0;
            held_d      = dist_mm;
          end
        end
      end
      res_d.target_set     = 1'b1;
      res_d.target_down_mm = tdown;
      lut_d   = now;
      valid_d = 1'b1;
      if (timeout || rp_d || stamp_q != stamp) begin
        res_d.init_cmd     = 1'b1;
        res_d.init_down_mm = tdown;
        rp_d    = 1'b0;
        stamp_d = stamp;
      end
    end else if (timeout && !rp_d) begin
      // sensor lost: reinit to zero and wipe the memory
      res_d.init_cmd = 1'b1;
      valid_d     = 1'b0;
      rp_d        = 1'b1;
      held_d      = '0;
      gap_start_d = '0;
      gap_act_d   = 1'b0;
    end
    res_d.logging_valid = valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_sel_q <= SurfaceRst;
      timeout_q  <= TimeoutRst;
      gap_thr_q  <= GapThrRst;
      gap_hold_q <= GapHoldRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgSurface: surf_sel_q <= cfg_wdata_i[1:0];
        CfgTimeout: timeout_q  <= cfg_wdata_i;
        CfgGapThr:  gap_thr_q  <= cfg_wdata_i;
        CfgGapHold: gap_hold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      lut_q       <= '0;
      rp_q        <= 1'b0;
      stamp_q     <= '0;
      held_q      <= '0;
      gap_start_q <= '0;
      gap_act_q   <= 1'b0;
      valid_q     <= 1'b0;
      applied_q   <= SurfGround;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q   <= 1'b1;
        lut_q       <= lut_d;
        rp_q        <= rp_d;
        stamp_q     <= stamp_d;
        held_q      <= held_d;
        gap_start_q <= gap_start_d;
        gap_act_q   <= gap_act_d;
        valid_q     <= valid_d;
        applied_q   <= applied_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_mode_q <= s_axis_tuser;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  `SDGH_ASSERT_NXT(a_in_hold, in_vld_q && !advance, in_vld_q, "input beat dropped while stalled")
  `SDGH_ASSERT_IMP(a_tdown_zero, out_vld_q && !out_q.target_set,
                   out_q.target_down_mm == '0, "target value without target_set")
  `SDGH_ASSERT_IMP(a_init_match, out_vld_q && out_q.init_cmd && out_q.target_set,
                   out_q.init_down_mm == out_q.target_down_mm, "init value differs from target")
  `SDGH_ASSERT_IMP(a_loss_zero, out_vld_q && out_q.init_cmd && !out_q.target_set,
                   out_q.init_down_mm == '0 && !out_q.logging_valid, "loss reinit not zero")
  `SDGH_ASSERT_IMP(a_gap_ground, gap_act_q, applied_q == SurfGround,
                   "gap timing active off the ground surface")

endmodule

// File: sim/sdgh_track_pkg.sv
// Scoreboard for the surface distance gap hold core testbench: tracking predictor and
// expected-result store. Depends on sdgh_pkg for the field layout and result type.
`timescale 1ns / 1ps

package sdgh_track_pkg;
  import sdgh_pkg::*;

  // tuser codes on the update stream
  localparam logic KindSample = 1'b0;
  localparam logic KindRearm  = 1'b1;
  // Selector value with no surface behind it; tracks like none
  localparam logic [1:0] SurfUnused = 2'd3;

  class track_checker;
    // register copies
    logic [1:0]  surf_sel;
    logic [15:0] timeout_ms;
    logic [15:0] gap_thr_mm;
    logic [15:0] gap_hold_ms;
    // tracking state
    logic [31:0] last_fix_ms;
    logic [31:0] last_stamp;
    logic [31:0] gap_start_ms;
    logic [15:0] held_mm;
    bit          reinit_pending;
    bit          gap_running;
    bit          target_valid;
    surf_e       applied_surf;

    res_t        expected_q[$];
    int unsigned failures;
    int unsigned checked;

    function new();
      surf_sel       = SurfaceRst;
      timeout_ms     = TimeoutRst;
      gap_thr_mm     = GapThrRst;
      gap_hold_ms    = GapHoldRst;
      last_fix_ms    = '0;
      last_stamp     = '0;
      gap_start_ms   = '0;
      held_mm        = '0;
      reinit_pending = 1'b0;
      gap_running    = 1'b0;
      target_valid   = 1'b0;
      applied_surf   = SurfGround;
      failures       = 0;
      checked        = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CfgSurface: surf_sel = v[1:0];
        CfgTimeout: timeout_ms = v;
        CfgGapThr:  gap_thr_mm = v;
        CfgGapHold: gap_hold_ms = v;
        default: ;
      endcase
    endfunction

    function void forget_distance();
      held_mm      = '0;
      gap_start_ms = '0;
      gap_running  = 1'b0;
    endfunction

    // Negated tilt-corrected distance, rounded half away from zero, saturated
    function logic signed [OutW-1:0] tilt_down(logic [15:0] mm_in, logic [15:0] tilt);
      longint mag;
      longint q;
      longint dn;
      mag = tilt[15] ? 65536 - longint'(tilt) : longint'(tilt);
      q = (longint'(mm_in) * mag + 8192) >>> 14;
      dn = tilt[15] ? q : -q;
      if (dn > longint'(OutLimit)) dn = longint'(OutLimit);
      if (dn < -longint'(OutLimit)) dn = -longint'(OutLimit);
      return dn[OutW-1:0];
    endfunction

    function void note_update(logic kind, logic [InDataW-1:0] d);
      logic [31:0] now_ms;
      logic [31:0] stamp;
      logic [15:0] dist_mm;
      logic [15:0] tilt;
      logic [15:0] used_mm;
      bit          sane;
      bit          timed_out;
      surf_e       sel;
      res_t        r;
      now_ms  = d[InNowLo +: 32];
      stamp   = d[InStampLo +: 32];
      dist_mm = d[InDistLo +: DistW];
      tilt    = d[InTiltLo +: 16];
      sane    = d[InOkBit] && d[InGfBit];
      r       = '0;
      sel = (surf_sel == SurfUnused) ? SurfNone : surf_e'(surf_sel);
      if (sel != applied_surf) begin
        applied_surf   = sel;
        reinit_pending = 1'b1;
        forget_distance();
      end
      if (kind == KindRearm) begin
        if (applied_surf == SurfGround && sane) begin
          last_fix_ms    = now_ms;
          reinit_pending = 1'b0;
        end
      end else begin
        timed_out = (now_ms - last_fix_ms) > {16'd0, timeout_ms};
        if (sane && (applied_surf == SurfGround || applied_surf == SurfCeiling)) begin
          used_mm = dist_mm;
          if (applied_surf == SurfGround) begin
            if (!d[InAutoBit]) begin
              held_mm      = dist_mm;
              gap_running  = 1'b0;
              gap_start_ms = '0;
            end else begin
              if (held_mm <= MemEmptyMm) held_mm = dist_mm;
              if ({16'd0, dist_mm} > {16'd0, held_mm} + {16'd0, gap_thr_mm}) begin
                if (!gap_running) begin
                  gap_running  = 1'b1;
                  gap_start_ms = now_ms;
                end
                // hold the old distance until the gap has lasted long enough
                if ((now_ms - gap_start_ms) < {16'd0, gap_hold_ms}) used_mm = held_mm;
                else held_mm = dist_mm;
              end else begin
                gap_running  = 1'b0;
                gap_start_ms = '0;
                held_mm      = dist_mm;
              end
            end
          end
          r.target_set     = 1'b1;
          r.target_down_mm = tilt_down(used_mm, tilt);
          last_fix_ms      = now_ms;
          target_valid     = 1'b1;
          if (timed_out || reinit_pending || last_stamp != stamp) begin
            r.init_cmd     = 1'b1;
            r.init_down_mm = r.target_down_mm;
            reinit_pending = 1'b0;
            last_stamp     = stamp;
          end
        end else if (timed_out && !reinit_pending) begin
          // sensor lost too long: reinit to zero and wipe the memory
          r.init_cmd     = 1'b1;
          target_valid   = 1'b0;
          reinit_pending = 1'b1;
          forget_distance();
        end
      end
      r.logging_valid = target_valid;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      res_t got;
      res_t want;
      got.target_set     = d[0];
      got.target_down_mm = d[OutW:1];
      got.init_cmd       = d[OutW+1];
      got.init_down_mm   = d[2*OutW+1:OutW+2];
      got.logging_valid  = d[2*OutW+2];
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result beat %h arrived with nothing expected", d);
        return;
      end
      want = expected_q.pop_front();
      if (got.target_set !== want.target_set || got.target_down_mm !== want.target_down_mm ||
          got.init_cmd !== want.init_cmd || got.init_down_mm !== want.init_down_mm ||
          got.logging_valid !== want.logging_valid) begin
        failures++;
        if (failures <= 10)
          $display("result %0d mismatch: set %b/%b down %0d/%0d init %b/%b val %0d/%0d lv %b/%b",
                   checked, want.target_set, got.target_set, want.target_down_mm,
                   got.target_down_mm, want.init_cmd, got.init_cmd, want.init_down_mm,
                   got.init_down_mm, want.logging_valid, got.logging_valid);
      end
    endfunction
  endclass

endpackage

// File: sim/testbench.sv
// Testbench for surface_distance_gap_hold_core: streams rangefinder updates with random
// stalls on both sides and checks every result beat. Depends on sdgh_pkg and sdgh_track_pkg.
`timescale 1ns / 1ps

module testbench;
  import sdgh_pkg::*;
  import sdgh_track_pkg::*;

  localparam int StallLimit    = 5000;
  localparam int HoldOffCycles = 64;
  localparam int NumPhases     = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_addr_i = '0;
  logic [15:0]         cfg_wdata_i = '0;

  surface_distance_gap_hold_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  track_checker sb = new();

  // register settings per phase, extremes included
  logic [1:0]  ph_surface  [NumPhases] = '{2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd1};
  logic [15:0] ph_timeout  [NumPhases] = '{16'd1500, 16'd0, 16'd300, 16'd65535,
                                           16'd800, 16'd1000, 16'd2000, 16'd400};
  logic [15:0] ph_gap_thr  [NumPhases] = '{16'd500, 16'd0, 16'd65535, 16'd65535,
                                           16'd200, 16'd500, 16'd300, 16'd50};
  logic [15:0] ph_gap_hold [NumPhases] = '{16'd2500, 16'd0, 16'd65535, 16'd65535,
                                           16'd1000, 16'd500, 16'd800, 16'd1200};
  int          ph_updates  [NumPhases] = '{170, 140, 140, 150, 60, 60, 160, 150};

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned holdoffs = 0;
  int unsigned updates_sent = 0;
  int unsigned rearms_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;

  // stimulus shaping state
  logic [31:0] cur_now = '0;
  logic [31:0] cur_stamp = '0;
  int          ground_mm = 800;
  int          bad_left = 0;
  int          gap_left = 0;

  always #1 clk_i = ~clk_i;

  // receiver: random backpressure, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
        holdoffs++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("testbench: no beat moved for %0d cycles", StallLimit);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_update(logic kind, logic [31:0] now, bit ok, bit gf,
                             logic [15:0] dist_mm, logic [31:0] stamp, logic [15:0] tilt,
                             bit au);
    logic [InDataW-1:0] d;
    d = '0;
    d[InNowLo +: 32]     = now;
    d[InOkBit]           = ok;
    d[InGfBit]           = gf;
    d[InDistLo +: DistW] = dist_mm;
    d[InStampLo +: 32]   = stamp;
    d[InTiltLo +: 16]    = tilt;
    d[InAutoBit]         = au;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_update(kind, d);
    updates_sent++;
    if (kind == KindRearm) rearms_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    reg_writes++;
  endtask

  // One update of a plausible flight: steady terrain with noise, gap episodes,
  // sensor dropouts, stamp changes and the odd wild value
  task automatic random_update();
    int unsigned r;
    int          v;
    bit          ok;
    bit          gf;
    logic [15:0] tilt;
    r = $urandom_range(99);
    if (r < 65) cur_now += $urandom_range(150, 20);
    else if (r < 80) cur_now += $urandom_range(20);
    else if (r < 95) cur_now += $urandom_range(5000, 1000);
    else cur_now += $urandom;
    if (bad_left == 0 && $urandom_range(99) < 4) bad_left = $urandom_range(30, 1);
    if (bad_left > 0) begin
      bad_left--;
      ok = 1'($urandom_range(1));
      gf = 1'($urandom_range(1));
    end else begin
      ok = ($urandom_range(99) > 1);
      gf = ($urandom_range(99) > 1);
    end
    if ($urandom_range(99) < 5) cur_stamp = $urandom;
    if ($urandom_range(99) < 3) ground_mm = $urandom_range(4000);
    else ground_mm = ground_mm + int'($urandom_range(40)) - 20;
    if (ground_mm < 0) ground_mm = 0;
    if (gap_left == 0 && $urandom_range(99) < 5) gap_left = $urandom_range(40, 1);
    if (gap_left > 0) begin
      gap_left--;
      v = ground_mm + int'(sb.gap_thr_mm) + int'($urandom_range(3000, 1));
    end else if ($urandom_range(99) < 4) begin
      v = $urandom_range(65535);
    end else begin
      v = ground_mm + int'($urandom_range(30)) - 15;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    r = $urandom_range(99);
    if (r < 75) tilt = 16'($urandom_range(16384, 11000));
    else if (r < 93) tilt = 16'($urandom_range(32768) - 16384);
    else tilt = 16'($urandom);
    send_update(($urandom_range(99) < 6) ? KindRearm : KindSample, cur_now, ok, gf,
                16'(v), cur_stamp, tilt, ($urandom_range(99) < 90));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 22;
    rx_idle_pct = 81;

    // directed: gap hold and release, saturation, stamp change, loss, re-arm, time wrap
    send_update(KindSample, 32'd100, 1, 1, 16'd1000, 32'd0, 16'd16384, 1);
    send_update(KindSample, 32'd200, 1, 1, 16'd1200, 32'd0, 16'd16384, 1);
    send_update(KindSample, 32'd300, 1, 1, 16'd2500, 32'd0, 16'd16384, 1);
    send_update(KindSample, 32'd2900, 1, 1, 16'd2600, 32'd0, 16'd16384, 1);
    send_update(KindSample, 32'd3000, 1, 1, 16'hFFFF, 32'd0, 16'h8000, 1);
    send_update(KindSample, 32'd3100, 1, 1, 16'hFFFF, 32'd0, 16'h7FFF, 0);
    send_update(KindSample, 32'd3200, 1, 1, 16'd0, 32'd0, 16'h0000, 0);
    send_update(KindSample, 32'd3300, 1, 1, 16'd40, 32'hFFFF_FFFF, 16'hC000, 1);
    send_update(KindSample, 32'd9000, 0, 1, 16'd500, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindSample, 32'd9100, 1, 0, 16'd500, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindRearm, 32'd9200, 1, 0, 16'd500, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindRearm, 32'd9300, 1, 1, 16'd500, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindSample, 32'hFFFF_FF00, 1, 1, 16'd3000, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindSample, 32'h0000_0050, 1, 1, 16'd3100, 32'hFFFF_FFFF, 16'hFFFF, 1);
    send_update(KindSample, 32'h0000_0060, 1, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'd16384, 1);
    send_update(KindSample, 32'h7FFF_FFFF, 0, 0, 16'd0, 32'd0, 16'h8001, 0);
    send_update(KindSample, 32'h8000_0000, 1, 1, 16'hAAAA, 32'h5555_5555, 16'h5555, 1);
    cur_now   = 32'h8000_0000;
    cur_stamp = 32'h5555_5555;

    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      write_reg(CfgSurface, {14'd0, ph_surface[p]});
      write_reg(CfgTimeout, ph_timeout[p]);
      write_reg(CfgGapThr, ph_gap_thr[p]);
      write_reg(CfgGapHold, ph_gap_hold[p]);
      cfg_valid_i <= 1'b0;
      if (p < 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 81;
      end else if (p < 6) begin
        tx_idle_pct = 81;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < ph_updates[p]; n++) begin
        // stall the result side long enough to back up the input
        if (n == 20) hold_req = 1'b1;
        if (n == ph_updates[p] / 2) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        random_update();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("testbench: %0d updates (%0d re-arm) over %0d register settings, %0d writes",
             updates_sent, rearms_sent, NumPhases + 1, reg_writes);
    $display("testbench: %0d results checked, %0d mismatches, %0d long result stalls",
             sb.checked, sb.failures, holdoffs);
    if (sb.failures == 0 && sb.pending() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
